@@ hw/rtl/ztt_pkg.sv @@
// Shared constants for the zone text tokenizer: character codes, the
// default token limit and result field widths. No dependencies.
package ztt_pkg;

   localparam int unsigned MaxTokensDefault = 64;
   localparam int unsigned NumWidth         = 6;
   localparam int unsigned RspDataWidth     = 16;

   localparam logic [7:0] ChSemi   = 8'h3B;
   localparam logic [7:0] ChOpen   = 8'h28;
   localparam logic [7:0] ChClose  = 8'h29;
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChNl     = 8'h0A;
   localparam logic [7:0] ChFf     = 8'h0C;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChVt     = 8'h0B;
   localparam logic [7:0] ChCr     = 8'h0D;

endpackage

@@ hw/rtl/zone_text_tokenizer.sv @@
// Zone text tokenizer top level: per-byte token and record marking of
// DNS master file text. Depends on ztt_pkg.
//
// One text byte enters per cycle and one result leaves per cycle while the
// output is not stalled by rsp_tready; a byte passes through an input
// register, then the scanner logic into the result register. The scanner
// state updates as each byte advances, so bytes may arrive back to back.
// req_tlast marks the final byte of a text; after it all scanner
// state returns to its reset value. rsp_tlast flags the byte that ends a
// record holding at least one token. No clearing pass is needed after reset.
module zone_text_tokenizer #(
   parameter int unsigned MAX_TOKENS = ztt_pkg::MaxTokensDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] text_byte
   input  logic                            req_tlast,  // final_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] token_byte, [1] token_begin, [2] close_before, [3] close_after,
   // [9:4] token_number, [10] owner_omitted, [11] token_overflow, [15:12] 0
   output logic [ztt_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                            rsp_tlast   // record_end
);

   localparam int unsigned CntWidth = $clog2(MAX_TOKENS + 2);
   localparam int unsigned IdxWidth =
      (CntWidth > ztt_pkg::NumWidth) ? CntWidth : ztt_pkg::NumWidth;
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_TOKENS);
   localparam logic [IdxWidth-1:0] NumSat = IdxWidth'((1 << ztt_pkg::NumWidth) - 1);

   typedef enum logic [1:0] {
      MODE_BETWEEN,
      MODE_COMMENT,
      MODE_BARE,
      MODE_QUOTED
   } mode_type;

   logic                            in_valid_ff;
   logic [7:0]                      in_byte_ff;
   logic                            in_last_ff;

   mode_type                        mode_ff, mode_in;
   logic                            paren_ff, paren_in;
   logic                            esc_ff, esc_in;
   logic [CntWidth-1:0]             cnt_ff, cnt_in;
   logic                            start_ff, start_in;

   logic                            out_valid_ff;
   logic [ztt_pkg::RspDataWidth-1:0] out_data_ff, out_data_in;
   logic                            out_last_ff;

   logic                            advance;

   logic                            o_tb, o_begin, o_cb, o_ca, o_own, o_end, o_ovf;
   logic [ztt_pkg::NumWidth-1:0]    o_num;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      logic [7:0]          c;
      logic                is_sep;
      logic                is_space6;
      logic                do_nl;
      logic                do_mark;
      logic [CntWidth-1:0] mark_cnt;
      logic                end_ovf;
      logic [IdxWidth-1:0] idx;

      c         = in_byte_ff;
      is_sep    = (c == ztt_pkg::ChSpace) || (c == ztt_pkg::ChTab) || (c == ztt_pkg::ChFf);
      is_space6 = is_sep || (c == ztt_pkg::ChNl) || (c == ztt_pkg::ChVt)
                  || (c == ztt_pkg::ChCr);
      do_nl     = 1'b0;
      do_mark   = 1'b0;
      mark_cnt  = '0;
      end_ovf   = 1'b0;
      idx       = '0;

      mode_in  = mode_ff;
      paren_in = paren_ff;
      esc_in   = esc_ff;
      cnt_in   = cnt_ff;
      start_in = start_ff;

      o_tb    = 1'b0;
      o_begin = 1'b0;
      o_cb    = 1'b0;
      o_ca    = 1'b0;
      o_own   = 1'b0;
      o_end   = 1'b0;
      o_ovf   = 1'b0;
      o_num   = '0;

      case (mode_ff)
         MODE_COMMENT: begin
            if (c == ztt_pkg::ChNl) begin
               mode_in = MODE_BETWEEN;
               do_nl   = 1'b1;
            end
         end
         MODE_BARE: begin
            if (esc_ff && is_space6) begin
               esc_in   = 1'b0;
               o_tb     = 1'b1;
               do_mark  = 1'b1;
               mark_cnt = cnt_ff;
            end else begin
               esc_in = 1'b0;
               if (is_sep || c == ztt_pkg::ChNl || (c == ztt_pkg::ChClose && paren_ff)) begin
                  o_cb     = 1'b1;
                  do_mark  = 1'b1;
                  mark_cnt = cnt_ff;
                  mode_in  = MODE_BETWEEN;
                  if (c == ztt_pkg::ChNl) begin
                     do_nl = 1'b1;
                  end
                  if (c == ztt_pkg::ChClose) begin
                     paren_in = 1'b0;
                  end
               end else begin
                  o_tb     = 1'b1;
                  do_mark  = 1'b1;
                  mark_cnt = cnt_ff;
                  if (c == ztt_pkg::ChBslash && !paren_ff) begin
                     esc_in = 1'b1;
                  end
               end
            end
         end
         MODE_QUOTED: begin
            if (esc_ff && c == ztt_pkg::ChQuote) begin
               esc_in   = 1'b0;
               o_tb     = 1'b1;
               do_mark  = 1'b1;
               mark_cnt = cnt_ff;
            end else begin
               esc_in   = 1'b0;
               do_mark  = 1'b1;
               mark_cnt = cnt_ff;
               if (c == ztt_pkg::ChNl) begin
                  o_cb    = 1'b1;
                  mode_in = MODE_BETWEEN;
                  do_nl   = 1'b1;
               end else if (c == ztt_pkg::ChQuote) begin
                  o_tb    = 1'b1;
                  o_ca    = 1'b1;
                  mode_in = MODE_BETWEEN;
               end else begin
                  o_tb = 1'b1;
                  if (c == ztt_pkg::ChBslash) begin
                     esc_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            if (c == ztt_pkg::ChSemi) begin
               mode_in  = MODE_COMMENT;
               start_in = 1'b0;
            end else if (c == ztt_pkg::ChNl) begin
               do_nl = 1'b1;
            end else if (is_sep) begin
               start_in = 1'b0;
            end else if (c == ztt_pkg::ChOpen && !paren_ff) begin
               paren_in = 1'b1;
               start_in = 1'b0;
            end else if (c == ztt_pkg::ChClose && paren_ff) begin
               paren_in = 1'b0;
               start_in = 1'b0;
            end else begin
               // token begins here
               if (cnt_ff == '0) begin
                  o_own = !start_ff;
               end
               start_in = 1'b0;
               if (cnt_ff <= CntMax) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               o_tb     = 1'b1;
               o_begin  = 1'b1;
               do_mark  = 1'b1;
               mark_cnt = cnt_in;
               if (c == ztt_pkg::ChQuote) begin
                  mode_in = MODE_QUOTED;
               end else begin
                  mode_in = MODE_BARE;
                  if (c == ztt_pkg::ChBslash && !paren_ff) begin
                     esc_in = 1'b1;
                  end
               end
            end
         end
      endcase

      if (do_nl) begin
         if (paren_in) begin
            start_in = 1'b0;
         end else if (cnt_in != '0) begin
            o_end    = 1'b1;
            end_ovf  = (cnt_in > CntMax);
            cnt_in   = '0;
            start_in = 1'b1;
         end else begin
            start_in = 1'b1;
         end
      end

      if (in_last_ff) begin
         if (mode_in == MODE_BARE || mode_in == MODE_QUOTED) begin
            o_ca     = 1'b1;
            do_mark  = 1'b1;
            mark_cnt = cnt_in;
         end
         if (cnt_in != '0 && !o_end) begin
            o_end   = 1'b1;
            end_ovf = (cnt_in > CntMax);
         end
         mode_in  = MODE_BETWEEN;
         paren_in = 1'b0;
         esc_in   = 1'b0;
         cnt_in   = '0;
         start_in = 1'b1;
      end

      if (do_mark) begin
         if (mark_cnt != '0) begin
            idx = IdxWidth'(mark_cnt - 1'b1);
         end
         o_num = (idx > NumSat) ? NumSat[ztt_pkg::NumWidth-1:0] : idx[ztt_pkg::NumWidth-1:0];
         o_ovf = (mark_cnt > CntMax);
      end
      o_ovf = o_ovf || end_ovf;

      out_data_in = {4'b0000, o_ovf, o_own, o_num, o_ca, o_cb, o_begin, o_tb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_BETWEEN;
         paren_ff     <= 1'b0;
         esc_ff       <= 1'b0;
         cnt_ff       <= '0;
         start_ff     <= 1'b1;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= out_data_in;
            out_last_ff  <= o_end;
            mode_ff      <= mode_in;
            paren_ff     <= paren_in;
            esc_ff       <= esc_in;
            cnt_ff       <= cnt_in;
            start_ff     <= start_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   a_begin_is_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("token_begin without token_byte");

   a_owner_on_begin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[1])
      else $error("owner_omitted off a token start");

   a_close_not_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0] && !rsp_tdata[1])
      else $error("close_before on a token byte");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntMax + 1'b1)
      else $error("token count past saturation");

   a_escape_in_token: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (mode_ff == MODE_BARE || mode_ff == MODE_QUOTED))
      else $error("escape pending outside a token");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for zone_text_tokenizer: streams zone file text through
// the block and checks every per-byte result against a built-in scanner model.
// Depends on ztt_pkg and the zone_text_tokenizer RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TokLimit    = ztt_pkg::MaxTokensDefault;
   localparam int unsigned IndexMax    = (1 << ztt_pkg::NumWidth) - 1;
   localparam int unsigned StallLimit  = 4000;
   localparam int unsigned DrainCycles = 8;

   typedef enum logic [1:0] {ScanGap, ScanComment, ScanBare, ScanQuoted} scan_type;

   typedef struct packed {
      logic                         in_token;
      logic                         first_byte;
      logic                         cut_before;
      logic                         cut_after;
      logic [ztt_pkg::NumWidth-1:0] index;
      logic                         owner_gap;
      logic                         rec_end;
      logic                         overflow;
   } token_marks_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = '0;   // [7:0] text_byte
   logic                             req_tlast = 1'b0; // final_byte
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [0] token_byte, [1] token_begin, [2] close_before, [3] close_after,
   // [9:4] token_number, [10] owner_omitted, [11] token_overflow, [15:12] 0
   logic [ztt_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             rsp_tlast;        // record_end

   zone_text_tokenizer #(.MAX_TOKENS(TokLimit)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   token_marks_type expected_marks[$];
   int              mismatches = 0;
   int              items_sent = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     quiet_cycles = 0;

   // scanner model state
   scan_type        scan_state = ScanGap;
   logic            in_paren = 1'b0;
   logic            esc_pending = 1'b0;
   int unsigned     token_count = 0;
   logic            record_fresh = 1'b1;
   token_marks_type now_marks;

   function automatic bit is_blank(input logic [7:0] c);
      return c == ztt_pkg::ChSpace || c == ztt_pkg::ChTab || c == ztt_pkg::ChFf;
   endfunction

   function automatic void clear_scanner();
      scan_state   = ScanGap;
      in_paren     = 1'b0;
      esc_pending  = 1'b0;
      token_count  = 0;
      record_fresh = 1'b1;
   endfunction

   function automatic void note_token_index();
      int unsigned idx;
      idx = (token_count != 0) ? token_count - 1 : 0;
      now_marks.index    = (idx > IndexMax) ? ztt_pkg::NumWidth'(IndexMax)
                                            : ztt_pkg::NumWidth'(idx);
      now_marks.overflow = token_count > TokLimit;
   endfunction

   function automatic void close_record();
      now_marks.rec_end = 1'b1;
      if (token_count > TokLimit) now_marks.overflow = 1'b1;
      token_count  = 0;
      record_fresh = 1'b1;
   endfunction

   function automatic void on_line_break();
      if (in_paren) begin
         record_fresh = 1'b0;
      end else if (token_count != 0) begin
         close_record();
      end else begin
         record_fresh = 1'b1;
      end
   endfunction

   function automatic void open_token(input scan_type kind);
      if (token_count == 0) now_marks.owner_gap = !record_fresh;
      record_fresh = 1'b0;
      if (token_count <= TokLimit) token_count++;
      scan_state           = kind;
      now_marks.in_token   = 1'b1;
      now_marks.first_byte = 1'b1;
      note_token_index();
   endfunction

   function automatic void mark_token_byte();
      now_marks.in_token = 1'b1;
      note_token_index();
   endfunction

   function automatic void cut_token();
      now_marks.cut_before = 1'b1;
      note_token_index();
      scan_state = ScanGap;
   endfunction

   function automatic token_marks_type predict_marks(input logic [7:0] c, input logic fin);
      logic escaped;
      now_marks = '0;
      escaped   = 1'b0;
      if (scan_state == ScanComment) begin
         if (c == ztt_pkg::ChNl) begin
            scan_state = ScanGap;
            on_line_break();
         end
      end else if (scan_state == ScanBare) begin
         if (esc_pending) begin
            esc_pending = 1'b0;
            escaped = c == ztt_pkg::ChSpace || c == ztt_pkg::ChTab ||
                      c == ztt_pkg::ChNl || c == ztt_pkg::ChVt ||
                      c == ztt_pkg::ChFf || c == ztt_pkg::ChCr;
         end
         if (escaped) begin
            mark_token_byte();
         end else if (is_blank(c)) begin
            cut_token();
         end else if (c == ztt_pkg::ChNl) begin
            cut_token();
            on_line_break();
         end else if (c == ztt_pkg::ChClose && in_paren) begin
            cut_token();
            in_paren = 1'b0;
         end else begin
            mark_token_byte();
            if (c == ztt_pkg::ChBslash && !in_paren) esc_pending = 1'b1;
         end
      end else if (scan_state == ScanQuoted) begin
         if (esc_pending) begin
            esc_pending = 1'b0;
            escaped = c == ztt_pkg::ChQuote;
         end
         if (escaped) begin
            mark_token_byte();
         end else if (c == ztt_pkg::ChNl) begin
            cut_token();
            on_line_break();
         end else if (c == ztt_pkg::ChQuote) begin
            mark_token_byte();
            now_marks.cut_after = 1'b1;
            scan_state = ScanGap;
         end else begin
            mark_token_byte();
            if (c == ztt_pkg::ChBslash) esc_pending = 1'b1;
         end
      end else begin
         if (c == ztt_pkg::ChSemi) begin
            scan_state   = ScanComment;
            record_fresh = 1'b0;
         end else if (c == ztt_pkg::ChNl) begin
            on_line_break();
         end else if (is_blank(c)) begin
            record_fresh = 1'b0;
         end else if (c == ztt_pkg::ChOpen && !in_paren) begin
            in_paren     = 1'b1;
            record_fresh = 1'b0;
         end else if (c == ztt_pkg::ChClose && in_paren) begin
            in_paren     = 1'b0;
            record_fresh = 1'b0;
         end else if (c == ztt_pkg::ChQuote) begin
            open_token(ScanQuoted);
         end else begin
            open_token(ScanBare);
            if (c == ztt_pkg::ChBslash && !in_paren) esc_pending = 1'b1;
         end
      end
      if (fin) begin
         if (scan_state == ScanBare || scan_state == ScanQuoted) begin
            now_marks.cut_after = 1'b1;
            note_token_index();
         end
         if (token_count != 0 && !now_marks.rec_end) close_record();
         clear_scanner();
      end
      return now_marks;
   endfunction

   task automatic send_byte(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_marks.push_back(predict_marks(c, fin));
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic fin_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_last && i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(2))
         0: return ztt_pkg::ChSpace;
         1: return ztt_pkg::ChTab;
         default: return ztt_pkg::ChFf;
      endcase
   endfunction

   function automatic logic [7:0] pick_name();
      string charset;
      charset = "abcdefghijklmnopqrstuvwxyz0123456789.-_*@$ABCXYZ";
      return charset[$urandom_range(charset.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_special();
      case ($urandom_range(10))
         0: return ztt_pkg::ChSemi;
         1: return ztt_pkg::ChOpen;
         2: return ztt_pkg::ChClose;
         3: return ztt_pkg::ChQuote;
         4: return ztt_pkg::ChBslash;
         5: return ztt_pkg::ChNl;
         6: return ztt_pkg::ChFf;
         7: return ztt_pkg::ChSpace;
         8: return ztt_pkg::ChTab;
         9: return ztt_pkg::ChVt;
         default: return ztt_pkg::ChCr;
      endcase
   endfunction

   task automatic send_bare();
      int len;
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(7) == 0) begin
            send_byte(ztt_pkg::ChBslash, 1'b0);
            send_byte($urandom_range(1) ? pick_special() : pick_name(), 1'b0);
         end else begin
            send_byte(pick_name(), 1'b0);
         end
      end
   endtask

   task automatic send_quoted();
      int len;
      len = $urandom_range(0, 5);
      send_byte(ztt_pkg::ChQuote, 1'b0);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5))
            0: begin
               send_byte(ztt_pkg::ChBslash, 1'b0);
               send_byte(ztt_pkg::ChQuote, 1'b0);
            end
            1: send_byte(pick_blank(), 1'b0);
            default: send_byte(pick_name(), 1'b0);
         endcase
      end
      send_byte(ztt_pkg::ChQuote, 1'b0);
   endtask

   task automatic send_record();
      int   ntok;
      logic paren_on;
      if ($urandom_range(15) == 0) send_byte(ztt_pkg::ChNl, 1'b0);
      if ($urandom_range(5) == 0) send_byte(pick_blank(), 1'b0);
      ntok = ($urandom_range(39) == 0) ? $urandom_range(TokLimit - 4, TokLimit + 6)
                                       : $urandom_range(1, 6);
      paren_on = 1'b0;
      for (int k = 0; k < ntok; k++) begin
         if (k > 0) begin
            send_byte(pick_blank(), 1'b0);
            if (paren_on && $urandom_range(3) == 0) send_byte(ztt_pkg::ChNl, 1'b0);
         end
         if (!paren_on && $urandom_range(9) == 0) begin
            send_byte(ztt_pkg::ChOpen, 1'b0);
            paren_on = 1'b1;
         end
         if ($urandom_range(3) == 0) send_quoted();
         else send_bare();
      end
      if (paren_on) send_byte(ztt_pkg::ChClose, 1'b0);
      if ($urandom_range(4) == 0) begin
         send_byte(ztt_pkg::ChSemi, 1'b0);
         repeat ($urandom_range(0, 4)) send_byte(pick_name(), 1'b0);
      end
      send_byte(ztt_pkg::ChNl, $urandom_range(9) == 0);
   endtask

   task automatic test_directed_cases();
      send_text(" x\n\n", 1'b0);              // owner omitted, then a blank line
      send_text("\"a\\\" b\"c", 1'b0);         // escaped quote, token right after quote
      send_byte(ztt_pkg::ChFf, 1'b0);
      send_text("(p\n) ;\n", 1'b0);           // newline inside parens, comment
      send_text("\\  \"q\n", 1'b0);           // escaped space, newline in quoted token
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);                 // token open at the final byte
      send_text("(;", 1'b1);                  // paren and comment open at the final byte
   endtask

   task automatic test_token_limit();
      for (int n = TokLimit; n <= TokLimit + 3; n += 3) begin
         for (int k = 0; k < n; k++) begin
            send_byte(pick_name(), 1'b0);
            send_byte(pick_blank(), 1'b0);
         end
         send_byte(ztt_pkg::ChNl, 1'b0);
      end
   endtask

   task automatic test_random_text(input int n_items);
      int target;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(99) < 80) begin
            send_record();
         end else begin
            repeat ($urandom_range(1, 8))
               send_byte($urandom_range(1) ? pick_special() : 8'($urandom_range(255)),
                         $urandom_range(39) == 0);
         end
      end
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      token_marks_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_marks.size() == 0) begin
               $display("%0t: result item with nothing expected, expected none, got %h/%b",
                        $time, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_marks.pop_front();
               check_field("token_byte", int'(want.in_token), int'(rsp_tdata[0]));
               check_field("token_begin", int'(want.first_byte), int'(rsp_tdata[1]));
               check_field("close_before", int'(want.cut_before), int'(rsp_tdata[2]));
               check_field("close_after", int'(want.cut_after), int'(rsp_tdata[3]));
               check_field("token_number", int'(want.index), int'(rsp_tdata[9:4]));
               check_field("owner_omitted", int'(want.owner_gap), int'(rsp_tdata[10]));
               check_field("token_overflow", int'(want.overflow), int'(rsp_tdata[11]));
               check_field("tdata padding", 0, int'(rsp_tdata[15:12]));
               check_field("record_end", int'(want.rec_end), int'(rsp_tlast));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("zone_text_tokenizer test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct  = 24;
      recv_stall_pct = 57;
      test_directed_cases();
      test_random_text(480);
      send_idle_pct  = 57;
      recv_stall_pct = 24;
      test_token_limit();
      test_random_text(480);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_text(480);
      req_tvalid <= 1'b0;
      while (expected_marks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) $display("zone_text_tokenizer test passed");
      else $display("zone_text_tokenizer test failed");
      $finish;
   end

endmodule
